FILE: design/afvol_pkg.sv
// shared constants, types and register codes for the audio frame fifo
`timescale 1ns / 1ps
`default_nettype none

package afvol_pkg;

  localparam int RING_FRAMES = 4096;
  localparam int ADDR_W      = $clog2(RING_FRAMES);
  localparam int POS_W       = $clog2(2 * RING_FRAMES);
  localparam int FREE_W      = 13;
  localparam int SAMPLE_W    = 16;
  localparam int FRAME_W     = 2 * SAMPLE_W;
  localparam int VOL_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;

  // sample * volume fits in 23 signed bits, its magnitude in 22
  localparam int PROD_W      = 23;
  localparam int MAG_W       = 22;

  // divide by 100 as (x * DIV_MUL) >> DIV_SHIFT, exact for x < 2**22
  localparam int DIV_SHIFT   = 29;
  localparam int DIV_MUL_W   = 23;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = 23'd5368710;
  localparam int QPROD_W     = MAG_W + DIV_MUL_W;

  localparam logic [VOL_W-1:0] VOL_MAX = 7'd100;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_STREAM_OPEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AUDIO_ENABLED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME        = 2'd3;

  typedef struct packed {
    logic             stream_open;
    logic             stereo_mode;
    logic             audio_enabled;
    logic [VOL_W-1:0] volume_percent;
  } afvol_cfg_t;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic div;
    logic mem_wr;
    logic mem_rd;
    logic res_load;
    logic res_accepted;
    logic res_underrun;
    logic res_from_mem;
  } afvol_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } afvol_stat_t;

endpackage

`default_nettype wire

FILE: design/afvol_item_if.sv
// handshake channels: producer/consumer items, results and register writes
`timescale 1ns / 1ps
`default_nettype none

interface afvol_item_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 operation;
  logic signed [afvol_pkg::SAMPLE_W-1:0] left_sample;
  logic signed [afvol_pkg::SAMPLE_W-1:0] right_sample;
  logic                                 batch_end;

  modport source (output valid, operation, left_sample, right_sample, batch_end,
                  input ready);
  modport sink (input valid, operation, left_sample, right_sample, batch_end,
                output ready);
endinterface

interface afvol_result_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 accepted;
  logic signed [afvol_pkg::SAMPLE_W-1:0] out_left;
  logic signed [afvol_pkg::SAMPLE_W-1:0] out_right;
  logic                                 underrun;
  logic [afvol_pkg::FREE_W-1:0]          free_frames;

  modport source (output valid, accepted, out_left, out_right, underrun, free_frames,
                  input ready);
  modport sink (input valid, accepted, out_left, out_right, underrun, free_frames,
                output ready);
endinterface

interface afvol_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [afvol_pkg::CFG_IDX_W-1:0]  index;
  logic [afvol_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/afvol_regs.sv
// configuration registers and the cursor clear pulse
`timescale 1ns / 1ps
`default_nettype none

module afvol_regs (
  input  wire logic            clk,
  input  wire logic            rst,
  afvol_cfg_if.sink            cfg,
  output afvol_pkg::afvol_cfg_t regs,
  output logic                 pos_clear
);

  logic wr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid;
  // any write to stream_open restarts both cursors
  assign pos_clear = wr && (cfg.index == afvol_pkg::REG_STREAM_OPEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.stream_open    <= 1'b0;
      regs.stereo_mode    <= 1'b1;
      regs.audio_enabled  <= 1'b1;
      regs.volume_percent <= afvol_pkg::VOL_MAX;
    end else if (wr) begin
      unique case (cfg.index)
        afvol_pkg::REG_STREAM_OPEN:   regs.stream_open    <= cfg.data[0];
        afvol_pkg::REG_STEREO_MODE:   regs.stereo_mode    <= cfg.data[0];
        afvol_pkg::REG_AUDIO_ENABLED: regs.audio_enabled  <= cfg.data[0];
        afvol_pkg::REG_VOLUME:        regs.volume_percent <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/afvol_ctrl.sv
// controller: decides each item's path and sequences the datapath
`timescale 1ns / 1ps
`default_nettype none

module afvol_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             operation,
  input  wire logic             batch_end,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  afvol_pkg::afvol_cfg_t  regs,
  input  afvol_pkg::afvol_stat_t stat,
  output afvol_pkg::afvol_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_RES  = 3'd5;

  logic [2:0] state, state_next;
  logic       batch_refused, batch_refused_next;
  logic       res_accepted, res_accepted_next;
  logic       res_underrun, res_underrun_next;
  logic       res_from_mem, res_from_mem_next;
  logic       out_valid_next;
  logic       accept;
  logic       mute;
  logic       refuse_set;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign mute     = !regs.audio_enabled || (regs.volume_percent == '0);

  always_comb begin
    state_next         = state;
    batch_refused_next = batch_refused;
    res_accepted_next  = res_accepted;
    res_underrun_next  = res_underrun;
    res_from_mem_next  = res_from_mem;
    out_valid_next     = out_valid;
    refuse_set         = 1'b0;
    cmd                = '0;
    cmd.res_accepted   = res_accepted;
    cmd.res_underrun   = res_underrun;
    cmd.res_from_mem   = res_from_mem;

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load_in       = 1'b1;
          res_accepted_next = 1'b0;
          res_underrun_next = 1'b0;
          res_from_mem_next = 1'b0;
          state_next        = S_RES;
          if (operation == afvol_pkg::OP_PUSH) begin
            if (batch_refused) begin
              res_accepted_next = 1'b0;
            end else if (!regs.stream_open) begin
              refuse_set = 1'b1;
            end else if (mute) begin
              res_accepted_next = 1'b1;
            end else if (stat.full) begin
              refuse_set = 1'b1;
            end else begin
              res_accepted_next = 1'b1;
              state_next        = S_MUL;
            end
            // batch end clears refusal after this frame is handled
            if (batch_end) begin
              batch_refused_next = 1'b0;
            end else if (refuse_set) begin
              batch_refused_next = 1'b1;
            end
          end else if (regs.stream_open) begin
            if (stat.empty) begin
              res_underrun_next = 1'b1;
            end else begin
              res_from_mem_next = 1'b1;
              state_next        = S_RD;
            end
          end
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div    = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.mem_wr = 1'b1;
        state_next = S_RES;
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_RES;
      end
      S_RES: begin
        // result register free, or being emptied this cycle
        if (!out_valid || out_ready) begin
          cmd.res_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      batch_refused <= 1'b0;
      out_valid     <= 1'b0;
      res_accepted  <= 1'b0;
      res_underrun  <= 1'b0;
      res_from_mem  <= 1'b0;
    end else begin
      state         <= state_next;
      batch_refused <= batch_refused_next;
      out_valid     <= out_valid_next;
      res_accepted  <= res_accepted_next;
      res_underrun  <= res_underrun_next;
      res_from_mem  <= res_from_mem_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/afvol_datapath.sv
// datapath: volume scaling lanes, frame memory, cursors and result register
`timescale 1ns / 1ps
`default_nettype none

module afvol_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  afvol_pkg::afvol_cfg_t                       regs,
  input  wire logic                                  pos_clear,
  input  afvol_pkg::afvol_cmd_t                       cmd,
  output afvol_pkg::afvol_stat_t                      stat,
  input  wire logic signed [afvol_pkg::SAMPLE_W-1:0] left_sample,
  input  wire logic signed [afvol_pkg::SAMPLE_W-1:0] right_sample,
  output logic                                       accepted,
  output logic signed [afvol_pkg::SAMPLE_W-1:0]      out_left,
  output logic signed [afvol_pkg::SAMPLE_W-1:0]      out_right,
  output logic                                       underrun,
  output logic [afvol_pkg::FREE_W-1:0]               free_frames
);

  localparam logic [afvol_pkg::POS_W-1:0] RING = afvol_pkg::POS_W'(afvol_pkg::RING_FRAMES);

  logic [afvol_pkg::FRAME_W-1:0] mem [afvol_pkg::RING_FRAMES];
  logic [afvol_pkg::FRAME_W-1:0] rd_data;
  logic [afvol_pkg::FRAME_W-1:0] wr_word;

  logic [afvol_pkg::POS_W-1:0]  wr_ptr;
  logic [afvol_pkg::POS_W-1:0]  rd_ptr;
  logic [afvol_pkg::POS_W-1:0]  queued;
  logic [afvol_pkg::FREE_W-1:0] free_calc;

  logic [afvol_pkg::VOL_W-1:0]   vol_eff;
  logic signed [afvol_pkg::SAMPLE_W-1:0] smp_l, smp_r;
  logic signed [23:0]            mul_l_full, mul_r_full;
  logic [afvol_pkg::PROD_W-1:0]  prod_l, prod_r;
  logic [afvol_pkg::PROD_W-1:0]  abs_l, abs_r;
  logic [afvol_pkg::QPROD_W-1:0] qprod_l, qprod_r;
  logic [afvol_pkg::SAMPLE_W-1:0] quot_l, quot_r;
  logic                          neg_l, neg_r;
  logic [afvol_pkg::SAMPLE_W-1:0] scaled_l, scaled_r;

  assign vol_eff = (regs.volume_percent > afvol_pkg::VOL_MAX) ? afvol_pkg::VOL_MAX
                                                               : regs.volume_percent;

  // cursors run modulo twice the ring so full and empty differ
  assign queued     = wr_ptr - rd_ptr;
  assign stat.full  = (queued >= RING);
  assign stat.empty = (queued == '0) || (queued > RING);
  assign free_calc  = !regs.stream_open ? '0 :
                      (queued >= RING)  ? '0 : afvol_pkg::FREE_W'(RING - queued);

  // stage 1: sample times volume
  assign mul_l_full = smp_l * $signed({1'b0, vol_eff});
  assign mul_r_full = smp_r * $signed({1'b0, vol_eff});

  // stage 2: magnitude divided by 100 through the reciprocal
  assign abs_l   = prod_l[afvol_pkg::PROD_W-1] ? (~prod_l + 1'b1) : prod_l;
  assign abs_r   = prod_r[afvol_pkg::PROD_W-1] ? (~prod_r + 1'b1) : prod_r;
  assign qprod_l = afvol_pkg::QPROD_W'(abs_l[afvol_pkg::MAG_W-1:0])
                 * afvol_pkg::QPROD_W'(afvol_pkg::DIV_MUL);
  assign qprod_r = afvol_pkg::QPROD_W'(abs_r[afvol_pkg::MAG_W-1:0])
                 * afvol_pkg::QPROD_W'(afvol_pkg::DIV_MUL);

  // stage 3: restore sign, truncation toward zero
  assign scaled_l = neg_l ? (~quot_l + 1'b1) : quot_l;
  assign scaled_r = neg_r ? (~quot_r + 1'b1) : quot_r;
  assign wr_word  = {scaled_r, scaled_l};

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      smp_l <= left_sample;
      smp_r <= regs.stereo_mode ? right_sample : left_sample;
    end
    if (cmd.mul) begin
      prod_l <= mul_l_full[afvol_pkg::PROD_W-1:0];
      prod_r <= mul_r_full[afvol_pkg::PROD_W-1:0];
    end
    if (cmd.div) begin
      quot_l <= qprod_l[afvol_pkg::DIV_SHIFT +: afvol_pkg::SAMPLE_W];
      quot_r <= qprod_r[afvol_pkg::DIV_SHIFT +: afvol_pkg::SAMPLE_W];
      neg_l  <= prod_l[afvol_pkg::PROD_W-1];
      neg_r  <= prod_r[afvol_pkg::PROD_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[wr_ptr[afvol_pkg::ADDR_W-1:0]] <= wr_word;
    end
    if (cmd.mem_rd) begin
      rd_data <= mem[rd_ptr[afvol_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || pos_clear) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (cmd.mem_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd.mem_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      accepted    <= cmd.res_accepted;
      underrun    <= cmd.res_underrun;
      out_left    <= cmd.res_from_mem ? rd_data[afvol_pkg::SAMPLE_W-1:0] : '0;
      out_right   <= cmd.res_from_mem ? rd_data[afvol_pkg::FRAME_W-1:afvol_pkg::SAMPLE_W]
                                      : '0;
      free_frames <= free_calc;
    end
  end

  a_wr_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_wr |-> (queued < RING))
    else $error("frame written into a full ring");

  a_rd_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_rd |-> (queued != '0))
    else $error("frame read from an empty ring");

  a_queued_bound: assert property (@(posedge clk) disable iff (rst)
    $past(rst) == 1'b0 |-> (queued <= RING))
    else $error("queued frame count beyond ring size");

  a_clear_cursors: assert property (@(posedge clk) disable iff (rst)
    pos_clear |=> (wr_ptr == '0) && (rd_ptr == '0))
    else $error("cursors not cleared by stream_open write");

endmodule

`default_nettype wire

FILE: design/audio_frame_fifo_with_volume.sv
// top level of the stereo audio frame fifo with volume scaling
`timescale 1ns / 1ps
`default_nettype none

// Stereo frame fifo of 4096 frames with volume scaling on the write side.
// One item is handled at a time. A producer frame that gets stored goes
// through multiply by volume, divide by 100 through a reciprocal multiply,
// memory write and result before the next acceptance; a consumer pop that
// reads the frame memory goes through a registered memory read and result;
// every other item (refused, muted, underrun, closed stream) goes straight to
// the result. A new item is taken as soon as the result is in the output
// register, so a stalled result side holds the block only when a second
// result is ready. Register writes are taken at any time, one per cycle;
// a write of stream_open empties the fifo. The frame memory needs no
// clearing after reset: only written slots are ever read.
module audio_frame_fifo_with_volume (
  input  wire logic       clk,
  input  wire logic       rst,
  afvol_item_if.sink      item_in,
  afvol_result_if.source  result_out,
  afvol_cfg_if.sink       cfg
);

  afvol_pkg::afvol_cfg_t  regs;
  afvol_pkg::afvol_cmd_t  cmd;
  afvol_pkg::afvol_stat_t stat;
  logic                   pos_clear;

  afvol_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .regs      (regs),
    .pos_clear (pos_clear)
  );

  afvol_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_in.valid),
    .in_ready  (item_in.ready),
    .operation (item_in.operation),
    .batch_end (item_in.batch_end),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .regs      (regs),
    .stat      (stat),
    .cmd       (cmd)
  );

  afvol_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .regs         (regs),
    .pos_clear    (pos_clear),
    .cmd          (cmd),
    .stat         (stat),
    .left_sample  (item_in.left_sample),
    .right_sample (item_in.right_sample),
    .accepted     (result_out.accepted),
    .out_left     (result_out.out_left),
    .out_right    (result_out.out_right),
    .underrun     (result_out.underrun),
    .free_frames  (result_out.free_frames)
  );

endmodule

`default_nettype wire

FILE: verif/tb_audio_frame_fifo_with_volume.sv
// self-checking testbench for the audio frame fifo with volume scaling
`timescale 1ns / 1ps

module tb_audio_frame_fifo_with_volume;
  import afvol_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RANDOM_PHASES   = 14;
  localparam int PHASE_BEATS     = 105;
  localparam int TAIL_BEATS      = 60;

  typedef struct packed {
    logic                       accepted;
    logic signed [SAMPLE_W-1:0] out_l;
    logic signed [SAMPLE_W-1:0] out_r;
    logic                       underrun;
    logic [FREE_W-1:0]          free_slots;
  } frame_reply_t;

  typedef struct packed {
    logic                       is_reg;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CFG_DATA_W-1:0]      data;
    logic                       op;
    logic signed [SAMPLE_W-1:0] l;
    logic signed [SAMPLE_W-1:0] r;
    logic                       last;
    logic                       typed;
    frame_reply_t               want;
  } dir_row_t;

  logic clk;
  logic rst;

  afvol_item_if   item_bus ();
  afvol_result_if result_bus ();
  afvol_cfg_if    cfg_bus ();

  audio_frame_fifo_with_volume i_dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_bus),
    .result_out (result_bus),
    .cfg        (cfg_bus)
  );

  // mirror of the fifo: frame ring, cursors, refusal and registers
  logic [FRAME_W-1:0] ring [0:RING_FRAMES-1];
  logic [POS_W-1:0]   wr_pos;
  logic [POS_W-1:0]   rd_pos;
  bit                 refusing;
  bit                 cf_open;
  bit                 cf_stereo;
  bit                 cf_enabled;
  logic [VOL_W-1:0]   cf_volume;

  frame_reply_t audio_replies [$];
  dir_row_t     directed_rows [$];
  frame_reply_t head;
  int           mismatches;
  int           tx_gap_max;
  int           rx_gap_max;
  bit           hold_off_req;
  int           quiet_cycles;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [SAMPLE_W-1:0] scale_sample(logic signed [SAMPLE_W-1:0] s, int vol);
    int prod;
    prod = int'(s) * vol / int'(VOL_MAX);  // int division truncates toward zero
    return prod[SAMPLE_W-1:0];
  endfunction

  function automatic frame_reply_t step_audio_fifo(logic op, logic signed [SAMPLE_W-1:0] l,
                                                   logic signed [SAMPLE_W-1:0] r, logic last);
    frame_reply_t rp;
    int vol;
    logic [POS_W-1:0] fill;
    logic signed [SAMPLE_W-1:0] r_src;
    rp = '0;
    vol = (cf_volume > VOL_MAX) ? int'(VOL_MAX) : int'(cf_volume);
    fill = wr_pos - rd_pos;
    if (op == OP_PUSH) begin
      if (refusing) begin
        rp.accepted = 1'b0;
      end else if (!cf_open) begin
        refusing = 1'b1;
      end else if (!cf_enabled || vol == 0) begin
        rp.accepted = 1'b1;
      end else if (fill >= RING_FRAMES) begin
        refusing = 1'b1;
      end else begin
        r_src = cf_stereo ? r : l;
        ring[wr_pos[ADDR_W-1:0]] = {scale_sample(r_src, vol), scale_sample(l, vol)};
        wr_pos = wr_pos + 1'b1;
        rp.accepted = 1'b1;
      end
      if (last) refusing = 1'b0;
    end else if (cf_open) begin
      if (fill == 0 || fill > RING_FRAMES) begin
        rp.underrun = 1'b1;
      end else begin
        {rp.out_r, rp.out_l} = ring[rd_pos[ADDR_W-1:0]];
        rd_pos = rd_pos + 1'b1;
      end
    end
    fill = wr_pos - rd_pos;
    if (!cf_open || fill >= RING_FRAMES) rp.free_slots = '0;
    else rp.free_slots = FREE_W'(RING_FRAMES - fill);
    return rp;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic frame_reply_t reply(bit acc, int l, int r, bit und, int fr);
    frame_reply_t rp;
    rp.accepted = acc;
    rp.out_l = SAMPLE_W'(l);
    rp.out_r = SAMPLE_W'(r);
    rp.underrun = und;
    rp.free_slots = FREE_W'(fr);
    return rp;
  endfunction

  function automatic dir_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    dir_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  function automatic dir_row_t beat_row(logic op, int l, int r, bit last);
    dir_row_t row;
    row = '0;
    row.op = op;
    row.l = SAMPLE_W'(l);
    row.r = SAMPLE_W'(r);
    row.last = last;
    return row;
  endfunction

  function automatic dir_row_t typed_row(dir_row_t row, frame_reply_t want);
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  // drop the item valid and let every outstanding beat come back
  task automatic wait_idle();
    item_bus.valid <= 1'b0;
    while (audio_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_STREAM_OPEN: begin
        cf_open = data[0];
        wr_pos = '0;
        rd_pos = '0;
      end
      REG_STEREO_MODE:   cf_stereo = data[0];
      REG_AUDIO_ENABLED: cf_enabled = data[0];
      REG_VOLUME:        cf_volume = data;
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
  endtask

  // one item beat; valid stays high across back-to-back beats
  task automatic drive_beat(logic op, logic signed [SAMPLE_W-1:0] l,
                            logic signed [SAMPLE_W-1:0] r, logic last,
                            logic typed, frame_reply_t want);
    int gap;
    frame_reply_t rp;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid        <= 1'b1;
    item_bus.operation    <= op;
    item_bus.left_sample  <= l;
    item_bus.right_sample <= r;
    item_bus.batch_end    <= last;
    do @(posedge clk); while (!item_bus.ready);
    rp = step_audio_fifo(op, l, r, last);
    audio_replies.push_back(typed ? want : rp);
  endtask

  task automatic run_phase(int count, int push_pct, int end_pct);
    logic op;
    for (int i = 0; i < count; i++) begin
      // every 64 beats, pick heavy idling or none at random
      if (i % 64 == 0) begin
        tx_gap_max = $urandom_range(0, 1) ? 17 : 0;
        rx_gap_max = $urandom_range(0, 1) ? 17 : 0;
      end
      op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
      drive_beat(op, pick_sample(), pick_sample(), $urandom_range(0, 99) < end_pct,
                 1'b0, '0);
    end
  endtask

  task automatic check_field(string field, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (audio_replies.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, accepted %0d left %0d right %0d", $time,
                 result_bus.accepted, result_bus.out_left, result_bus.out_right);
      end else begin
        head = audio_replies.pop_front();
        check_field("accepted", head.accepted, result_bus.accepted);
        check_field("out_left", head.out_l, result_bus.out_left);
        check_field("out_right", head.out_r, result_bus.out_right);
        check_field("underrun", head.underrun, result_bus.underrun);
        check_field("free_frames", head.free_slots, result_bus.free_frames);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stall per beat, one long hold-off on request
  initial begin
    int stall;
    result_bus.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = $urandom_range(0, rx_gap_max);
      if (hold_off_req) begin
        stall = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (stall > 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!result_bus.valid);
    end
  end

  initial begin
    dir_row_t row;
    logic [VOL_W-1:0] vol;
    rst = 1'b1;
    item_bus.valid = 1'b0;
    item_bus.operation = OP_PUSH;
    item_bus.left_sample = '0;
    item_bus.right_sample = '0;
    item_bus.batch_end = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_STREAM_OPEN;
    cfg_bus.data = '0;
    mismatches = 0;
    quiet_cycles = 0;
    hold_off_req = 1'b0;
    tx_gap_max = 17;
    rx_gap_max = 17;
    wr_pos = '0;
    rd_pos = '0;
    refusing = 1'b0;
    cf_open = 1'b0;
    cf_stereo = 1'b1;
    cf_enabled = 1'b1;
    cf_volume = VOL_MAX;

    // closed stream after reset, then the basic open-stream cases
    directed_rows.push_back(typed_row(beat_row(OP_PUSH, 0, 0, 0), reply(0, 0, 0, 0, 0)));
    directed_rows.push_back(typed_row(beat_row(OP_PUSH, 32767, -32768, 1),
                                      reply(0, 0, 0, 0, 0)));
    directed_rows.push_back(typed_row(beat_row(OP_POP, 0, 0, 0), reply(0, 0, 0, 0, 0)));
    directed_rows.push_back(reg_row(REG_STREAM_OPEN, 7'h01));
    directed_rows.push_back(typed_row(beat_row(OP_POP, 0, 0, 0), reply(0, 0, 0, 1, 4096)));
    directed_rows.push_back(typed_row(beat_row(OP_PUSH, 32767, -32768, 1),
                                      reply(1, 0, 0, 0, 4095)));
    directed_rows.push_back(typed_row(beat_row(OP_POP, 0, 0, 0),
                                      reply(0, 32767, -32768, 0, 4096)));
    directed_rows.push_back(beat_row(OP_PUSH, -32768, 32767, 0));
    directed_rows.push_back(reg_row(REG_VOLUME, 7'd50));
    directed_rows.push_back(typed_row(beat_row(OP_PUSH, -32768, 32767, 0),
                                      reply(1, 0, 0, 0, 4094)));
    directed_rows.push_back(beat_row(OP_PUSH, -1, 99, 0));
    // volume above full scale, then the smallest nonzero volume
    directed_rows.push_back(reg_row(REG_VOLUME, 7'd127));
    directed_rows.push_back(beat_row(OP_PUSH, 12345, -12345, 0));
    directed_rows.push_back(reg_row(REG_VOLUME, 7'd1));
    directed_rows.push_back(beat_row(OP_PUSH, -32768, 32767, 0));
    directed_rows.push_back(reg_row(REG_STEREO_MODE, 7'h7e));
    directed_rows.push_back(beat_row(OP_PUSH, -20000, 555, 0));
    // mute by zero volume, then by disable
    directed_rows.push_back(reg_row(REG_VOLUME, 7'd0));
    directed_rows.push_back(typed_row(beat_row(OP_PUSH, 1000, 1000, 0),
                                      reply(1, 0, 0, 0, 4090)));
    directed_rows.push_back(reg_row(REG_VOLUME, 7'd100));
    directed_rows.push_back(reg_row(REG_AUDIO_ENABLED, 7'h40));
    directed_rows.push_back(beat_row(OP_PUSH, 7, 7, 0));
    directed_rows.push_back(reg_row(REG_AUDIO_ENABLED, 7'h01));
    directed_rows.push_back(reg_row(REG_STEREO_MODE, 7'h7f));
    for (int i = 0; i < 6; i++) directed_rows.push_back(beat_row(OP_POP, 0, 0, 0));
    directed_rows.push_back(typed_row(beat_row(OP_POP, 0, 0, 0), reply(0, 0, 0, 1, 4096)));
    // refusal survives a reopen until the batch ends
    directed_rows.push_back(reg_row(REG_STREAM_OPEN, 7'h00));
    directed_rows.push_back(typed_row(beat_row(OP_PUSH, 3, 3, 0), reply(0, 0, 0, 0, 0)));
    directed_rows.push_back(reg_row(REG_STREAM_OPEN, 7'h7f));
    directed_rows.push_back(typed_row(beat_row(OP_PUSH, 5, 5, 0), reply(0, 0, 0, 0, 4096)));
    directed_rows.push_back(typed_row(beat_row(OP_PUSH, 6, 6, 1), reply(0, 0, 0, 0, 4096)));
    directed_rows.push_back(beat_row(OP_PUSH, 100, -100, 1));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_reg) write_reg(row.idx, row.data);
      else drive_beat(row.op, row.l, row.r, row.last, row.typed, row.want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 7)
        0: vol = VOL_MAX;
        1: vol = VOL_W'($urandom_range(1, 99));
        2: vol = '0;
        3: vol = VOL_W'($urandom_range(101, 127));
        4: vol = 7'd1;
        5: vol = VOL_W'($urandom_range(0, 127));
        default: vol = 7'd99;
      endcase
      write_reg(REG_VOLUME, vol);
      if ($urandom_range(0, 1))
        write_reg(REG_STEREO_MODE, {6'($urandom), 1'($urandom_range(0, 3) != 0)});
      if ($urandom_range(0, 1))
        write_reg(REG_AUDIO_ENABLED, {6'($urandom), 1'($urandom_range(0, 7) != 0)});
      if (p % 5 == 3) write_reg(REG_STREAM_OPEN, {6'($urandom), 1'b0});
      else if (!cf_open || $urandom_range(0, 3) == 0)
        write_reg(REG_STREAM_OPEN, {6'($urandom), 1'b1});
      case (p % 3)
        0: run_phase(PHASE_BEATS, 30, 25);
        1: run_phase(PHASE_BEATS, 50, 25);
        default: run_phase(PHASE_BEATS, 70, 25);
      endcase
    end

    // pushes against a long result hold-off, then drain into underrun
    write_reg(REG_STREAM_OPEN, {6'($urandom), 1'b1});
    write_reg(REG_AUDIO_ENABLED, 7'h01);
    write_reg(REG_STEREO_MODE, {6'($urandom), 1'($urandom_range(0, 1))});
    write_reg(REG_VOLUME, VOL_W'($urandom_range(1, 127)));
    hold_off_req = 1'b1;
    run_phase(TAIL_BEATS, 99, 2);
    run_phase(TAIL_BEATS, 2, 25);

    wait_idle();
    if (mismatches == 0 && audio_replies.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
design/afvol_pkg.sv
design/afvol_item_if.sv
design/afvol_regs.sv
design/afvol_ctrl.sv
design/afvol_datapath.sv
design/audio_frame_fifo_with_volume.sv
verif/tb_audio_frame_fifo_with_volume.sv
